// ===== src/chained_hash_table_top_defines.svh =====
// Assertion macros for the chained hash table block.
`ifndef CHAINED_HASH_TABLE_TOP_DEFINES_SVH
`define CHAINED_HASH_TABLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Plain property check, sampled on the rising clock edge, off during reset.
`define CHT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("chained hash table check failed");
// Implication check: whenever ante holds, cons must hold in the same cycle.
`define CHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chained hash table implication failed");
`else
`define CHT_ASSERT(lbl, clk, rst_n, prop)
`define CHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/cht_pkg.sv =====
// Shared constants for the chained hash table.
package cht_pkg;

    localparam int KEY_W    = 64;
    localparam int BC_W     = 11;
    localparam int CNT_O_W  = 11;
    localparam int OUT_V_W  = 32;
    localparam int DIV_STEPS = 64;

    localparam logic [BC_W-1:0] BC_RESET = 11'h3a9;

    // register index
    localparam logic REG_BUCKET_COUNT = 1'b0;

    // operation codes
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PRESENT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_POOL_FULL = 2'd3;

endpackage

// ===== src/cht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/chained_hash_table_top.sv =====
// Chained hash table top level: APB config, op sequencer, divider and pool memories.
//
// Usage: an operation (kind, key, value) is a transfer on the in_valid/in_ready
// channel; its one result (status, found_value, entry_count) is a transfer on
// out_valid/out_ready. One operation is in flight at a time: in_ready is high
// only while the sequencer is idle and no result is waiting.
// Each operation runs: accept, 64 divider steps (one remainder bit per cycle for
// key mod bucket_count), the bucket head read, a registered key/link memory read per
// chain node visited, the chain end check on a miss, the update states and the
// output state. With short chains the divider sets the floor and the chain walk
// through the pool memories adds to it.
// Reset and every write of bucket_count start a clearing pass over
// max(MAX_BUCKETS, NODE_POOL) entries that empties every bucket and threads the free
// list through all nodes; no operation is accepted during it, config writes are.
// A stalled receiver holds the result in the output register; no new operation is
// taken until it is transferred.
`include "chained_hash_table_top_defines.svh"

module chained_hash_table_top
    import cht_pkg::*;
#(
    parameter int NODE_POOL   = 1024,
    parameter int MAX_BUCKETS = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // operation channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic [KEY_W-1:0]    key,
    input  logic [31:0]         value,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [OUT_V_W-1:0]  found_value,
    output logic [CNT_O_W-1:0]  entry_count
);

    localparam int IW    = $clog2(NODE_POOL + 1);
    localparam int AW    = $clog2(NODE_POOL);
    localparam int BW    = $clog2(MAX_BUCKETS);
    localparam int CW    = $clog2(NODE_POOL + 1);
    localparam int CLR_N = (MAX_BUCKETS > NODE_POOL) ? MAX_BUCKETS : NODE_POOL;
    localparam int CLW   = $clog2(CLR_N);
    localparam int DCW   = $clog2(DIV_STEPS);
    localparam logic [IW-1:0] NIL = IW'(NODE_POOL);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_HEAD, S_HGOT, S_WALK, S_CMP,
        S_ACT, S_INS2, S_LINK, S_DEL2, S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [BC_W-1:0]        bc_reg, bc_next;
    logic [CLW-1:0]         clr_reg, clr_next;
    logic [1:0]             kind_reg, kind_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [KEY_W-1:0]       dsh_reg, dsh_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [BC_W-1:0]        rem_reg, rem_next;
    logic [DCW-1:0]         dcnt_reg, dcnt_next;
    logic [BW-1:0]          bkt_reg, bkt_next;
    logic [IW-1:0]          cur_reg, cur_next;
    logic [IW-1:0]          prev_reg, prev_next;
    logic [IW-1:0]          clink_reg, clink_next;
    logic                   found_reg, found_next;
    logic [IW-1:0]          fhead_reg, fhead_next;
    logic [IW-1:0]          newn_reg, newn_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [1:0]             st_reg, st_next;
    logic [OUT_V_W-1:0]     fval_reg, fval_next;

    // memory ports
    logic                   hd_we, lk_we, ky_we, vl_we;
    logic [BW-1:0]          hd_waddr;
    logic [IW-1:0]          hd_wdata, lk_wdata, hd_rdata, lk_rdata;
    logic [AW-1:0]          lk_waddr, lk_raddr, nd_waddr;
    logic [KEY_W-1:0]       ky_rdata;
    logic [VALUE_WIDTH-1:0] vl_rdata;

    // misc combinational values
    logic                   cfg_wr;
    logic [BC_W-1:0]        bc_eff;
    logic [BC_W:0]          div_t;
    logic [31:0]            rem_ext;
    logic [63:0]            val_ext;
    logic [63:0]            fval_ext;
    logic [31:0]            cnt_ext;

    cht_ram #(.WIDTH(IW), .DEPTH(MAX_BUCKETS)) u_heads (
        .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(bkt_reg), .rdata(hd_rdata)
    );

    cht_ram #(.WIDTH(IW), .DEPTH(NODE_POOL)) u_links (
        .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(lk_raddr), .rdata(lk_rdata)
    );

    cht_ram #(.WIDTH(KEY_W), .DEPTH(NODE_POOL)) u_keys (
        .clk(clk), .we(ky_we), .waddr(nd_waddr), .wdata(key_reg),
        .raddr(cur_reg[AW-1:0]), .rdata(ky_rdata)
    );

    cht_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(NODE_POOL)) u_vals (
        .clk(clk), .we(vl_we), .waddr(nd_waddr), .wdata(val_reg),
        .raddr(cur_reg[AW-1:0]), .rdata(vl_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BUCKET_COUNT);
    assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? 32'(bc_reg) : 32'd0;

    // effective modulus: zero acts as one, saturate at the bucket store depth
    always_comb
    begin
        if (bc_reg == '0)
        begin
            bc_eff = BC_W'(1);
        end
        else if (32'(bc_reg) > 32'(MAX_BUCKETS))
        begin
            bc_eff = BC_W'(MAX_BUCKETS);
        end
        else
        begin
            bc_eff = bc_reg;
        end
    end

    // handshake and result outputs
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign status      = st_reg;
    assign found_value = fval_reg;
    assign cnt_ext     = 32'(cnt_reg);
    assign entry_count = cnt_ext[CNT_O_W-1:0];

    assign div_t    = {rem_reg, dsh_reg[KEY_W-1]};
    assign rem_ext  = 32'(rem_next);
    assign val_ext  = 64'(value);
    assign fval_ext = 64'(vl_rdata);
    assign nd_waddr = fhead_reg[AW-1:0];
    assign lk_raddr = (state_reg == S_ACT) ? fhead_reg[AW-1:0] : cur_reg[AW-1:0];

    // sequencer next-state and memory write control
    always_comb
    begin
        state_next = state_reg;
        bc_next    = bc_reg;
        clr_next   = clr_reg;
        kind_next  = kind_reg;
        key_next   = key_reg;
        dsh_next   = dsh_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        bkt_next   = bkt_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        clink_next = clink_reg;
        found_next = found_reg;
        fhead_next = fhead_reg;
        newn_next  = newn_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        fval_next  = fval_reg;
        hd_we      = 1'b0;
        hd_waddr   = bkt_reg;
        hd_wdata   = NIL;
        lk_we      = 1'b0;
        lk_waddr   = cur_reg[AW-1:0];
        lk_wdata   = NIL;
        ky_we      = 1'b0;
        vl_we      = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // empty buckets and thread the free list, one entry a cycle
                hd_we    = (32'(clr_reg) < 32'(MAX_BUCKETS));
                hd_waddr = clr_reg[BW-1:0];
                hd_wdata = NIL;
                lk_we    = (32'(clr_reg) < 32'(NODE_POOL));
                lk_waddr = clr_reg[AW-1:0];
                lk_wdata = IW'(32'(clr_reg) + 32'd1);
                clr_next = clr_reg + CLW'(1);
                if (32'(clr_reg) == 32'(CLR_N - 1))
                begin
                    fhead_next = '0;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    key_next   = key;
                    dsh_next   = key;
                    val_next   = val_ext[VALUE_WIDTH-1:0];
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring remainder step, one key bit per cycle
                if (div_t >= {1'b0, bc_eff})
                begin
                    rem_next = BC_W'(div_t - {1'b0, bc_eff});
                end
                else
                begin
                    rem_next = div_t[BC_W-1:0];
                end
                dsh_next  = {dsh_reg[KEY_W-2:0], 1'b0};
                dcnt_next = dcnt_reg + DCW'(1);
                if (32'(dcnt_reg) == 32'(DIV_STEPS - 1))
                begin
                    bkt_next   = rem_ext[BW-1:0];
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_HGOT;
            end
            S_HGOT:
            begin
                cur_next   = hd_rdata;
                prev_next  = NIL;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (cur_reg >= NIL)
                begin
                    found_next = 1'b0;
                    state_next = S_ACT;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (ky_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    clink_next = lk_rdata;
                    fval_next  = fval_ext[OUT_V_W-1:0];
                    state_next = S_ACT;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = lk_rdata;
                    state_next = S_WALK;
                end
            end
            S_ACT:
            begin
                st_next    = ST_OK;
                state_next = S_OUT;
                if (!(found_reg && (kind_reg == KIND_FIND)))
                begin
                    fval_next = '0;
                end
                case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (found_reg)
                        begin
                            st_next = ST_PRESENT;
                        end
                        else if (fhead_reg >= NIL)
                        begin
                            st_next = ST_POOL_FULL;
                        end
                        else
                        begin
                            state_next = S_INS2;
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            st_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            if (prev_reg >= NIL)
                            begin
                                hd_we    = 1'b1;
                                hd_wdata = clink_reg;
                            end
                            else
                            begin
                                lk_we    = 1'b1;
                                lk_waddr = prev_reg[AW-1:0];
                                lk_wdata = clink_reg;
                            end
                            state_next = S_DEL2;
                        end
                    end
                    KIND_FIND:
                    begin
                        if (!found_reg)
                        begin
                            st_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end
            S_INS2:
            begin
                // new node from the free list head, appended at the tail
                ky_we      = 1'b1;
                vl_we      = 1'b1;
                lk_we      = 1'b1;
                lk_waddr   = fhead_reg[AW-1:0];
                lk_wdata   = NIL;
                fhead_next = lk_rdata;
                newn_next  = fhead_reg;
                cnt_next   = cnt_reg + CW'(1);
                if (prev_reg >= NIL)
                begin
                    hd_we      = 1'b1;
                    hd_wdata   = fhead_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                lk_we      = 1'b1;
                lk_waddr   = prev_reg[AW-1:0];
                lk_wdata   = newn_reg;
                state_next = S_OUT;
            end
            S_DEL2:
            begin
                // freed node goes on top of the free list
                lk_we      = 1'b1;
                lk_waddr   = cur_reg[AW-1:0];
                lk_wdata   = fhead_reg;
                fhead_next = cur_reg;
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // a bucket_count register write empties the table
        if (cfg_wr)
        begin
            bc_next    = pwdata[BC_W-1:0];
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            bc_reg    <= BC_RESET;
            clr_reg   <= '0;
            fhead_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bc_reg    <= bc_next;
            clr_reg   <= clr_next;
            fhead_reg <= fhead_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        key_reg   <= key_next;
        dsh_reg   <= dsh_next;
        val_reg   <= val_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        bkt_reg   <= bkt_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        clink_reg <= clink_next;
        found_reg <= found_next;
        newn_reg  <= newn_next;
        st_reg    <= st_next;
        fval_reg  <= fval_next;
    end

    // checks
    `CHT_ASSERT(a_one_side, clk, rst_n, !(in_ready && out_valid))
    `CHT_ASSERT(a_cnt_range, clk, rst_n, 32'(cnt_reg) <= 32'(NODE_POOL))
    `CHT_ASSERT_IMP(a_pool_full, clk, rst_n, in_ready,
        ((fhead_reg >= NIL) == (32'(cnt_reg) == 32'(NODE_POOL))))
    `CHT_ASSERT_IMP(a_bucket_range, clk, rst_n, state_reg == S_HEAD,
        32'(bkt_reg) < 32'(bc_eff))

endmodule

// ===== test/tb_chained_hash_table_top.sv =====
// Testbench for the chained hash table: predicting scoreboard, APB writes, random traffic.
module tb_chained_hash_table_top;
    import cht_pkg::*;

    localparam int POOL_SIZE   = 1024;
    localparam int BUCKET_MAX  = 1024;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 100;
    localparam logic [2:0] ADDR_BUCKET_COUNT = {REG_BUCKET_COUNT, 2'b00};
    localparam logic [2:0] ADDR_UNUSED       = 3'd4;
    localparam logic [1:0] KIND_IGNORED      = 2'd3;

    // Scoreboard: mirrors the table and queues expected results in order.
    class ht_scoreboard;
        typedef struct {
            logic [1:0]         st;
            logic [OUT_V_W-1:0] fval;
            logic [CNT_O_W-1:0] cnt;
        } ht_result_t;

        int               heads[BUCKET_MAX];
        logic [63:0]      node_key[POOL_SIZE];
        logic [31:0]      node_val[POOL_SIZE];
        int               node_next[POOL_SIZE];
        int               free_head;
        int               entries;
        int               buckets;
        ht_result_t       pending_q[$];
        int               mismatches;

        function void clear_table();
            for (int i = 0; i < BUCKET_MAX; i++) heads[i] = POOL_SIZE;
            for (int i = 0; i < POOL_SIZE; i++) node_next[i] = i + 1;
            free_head = 0;
            entries = 0;
        endfunction

        // bucket count register write: zero acts as one, large saturates
        function void set_buckets(logic [31:0] wdata);
            buckets = int'(wdata[10:0]);
            if (buckets == 0) buckets = 1;
            if (buckets > BUCKET_MAX) buckets = BUCKET_MAX;
            clear_table();
        endfunction

        function void note_op(logic [1:0] op, logic [63:0] k, logic [31:0] v);
            ht_result_t r;
            logic [63:0] b64;
            int b, prev, cur, steps, n;
            bit hit;
            b64 = k % 64'(buckets);
            b = int'(b64);
            prev = POOL_SIZE;
            cur = heads[b];
            steps = 0;
            while (cur < POOL_SIZE && steps < POOL_SIZE && node_key[cur] != k) begin
                prev = cur;
                cur = node_next[cur];
                steps++;
            end
            hit = (cur < POOL_SIZE) && (node_key[cur] == k);
            r.st = ST_OK;
            r.fval = '0;
            if (op == KIND_INSERT) begin
                if (hit) r.st = ST_PRESENT;
                else if (free_head >= POOL_SIZE || cur < POOL_SIZE) r.st = ST_POOL_FULL;
                else begin
                    n = free_head;
                    free_head = node_next[n];
                    node_key[n] = k;
                    node_val[n] = v;
                    node_next[n] = POOL_SIZE;
                    if (prev >= POOL_SIZE) heads[b] = n;
                    else node_next[prev] = n;
                    entries++;
                end
            end else if (op == KIND_DELETE) begin
                if (!hit) r.st = ST_NOT_FOUND;
                else begin
                    if (prev >= POOL_SIZE) heads[b] = node_next[cur];
                    else node_next[prev] = node_next[cur];
                    node_next[cur] = free_head;
                    free_head = cur;
                    if (entries > 0) entries--;
                end
            end else if (op == KIND_FIND) begin
                if (hit) r.fval = node_val[cur];
                else r.st = ST_NOT_FOUND;
            end
            r.cnt = CNT_O_W'(entries);
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [OUT_V_W-1:0] fv,
                                   logic [CNT_O_W-1:0] cnt);
            ht_result_t e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status=%0d value=%h count=%0d", st, fv, cnt);
                return;
            end
            e = pending_q.pop_front();
            if (st !== e.st || fv !== e.fval || cnt !== e.cnt) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp status=%0d value=%h count=%0d, got %0d %h %0d",
                             e.st, e.fval, e.cnt, st, fv, cnt);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          kind = '0;
    logic [KEY_W-1:0]    key = '0;
    logic [31:0]         value = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          status;
    logic [OUT_V_W-1:0]  found_value;
    logic [CNT_O_W-1:0]  entry_count;

    ht_scoreboard        table_sb;
    bit                  idling_on = 1'b1;
    int                  stall_left = 0;
    int                  quiet_cycles = 0;
    logic [63:0]         known_keys[$];

    chained_hash_table_top dut (.*);

    always #1 clk = ~clk;

    // transfer monitor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) table_sb.note_op(kind, key, value);
            if (out_valid && out_ready) table_sb.check_result(status, found_value, entry_count);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side: random stall bursts
    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_op(logic [1:0] op, logic [63:0] k, logic [31:0] v);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        key <= k;
        value <= v;
        do @(posedge clk); while (!in_ready);
    endtask

    // hold off until every expected result is back, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (table_sb.pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] wdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_BUCKET_COUNT) table_sb.set_buckets(wdata);
    endtask

    function automatic logic [63:0] pick_key(int span);
        if (known_keys.size() != 0 && $urandom_range(0, 1) == 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        if (span > 0 && $urandom_range(0, 1) == 0) return 64'($urandom_range(0, span));
        return {$urandom, $urandom};
    endfunction

    // mixed traffic; span keeps keys small, cap bounds the set of reused keys
    task automatic run_random(int count, int span, int cap);
        int sel;
        logic [1:0] op;
        logic [63:0] k;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 19);
            op = (sel < 8) ? KIND_INSERT : (sel < 13) ? KIND_DELETE :
                 (sel < 19) ? KIND_FIND : KIND_IGNORED;
            k = pick_key(span);
            if (op == KIND_INSERT) begin
                known_keys.push_back(k);
                if (known_keys.size() > cap)
                    known_keys.delete($urandom_range(0, known_keys.size() - 1));
            end
            send_op(op, k, $urandom);
        end
    endtask

    initial begin
        table_sb = new();
        table_sb.set_buckets(32'(BC_RESET));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, collisions in one chain, every status but pool full
        send_op(KIND_INSERT, 64'd0, 32'h0);
        send_op(KIND_INSERT, '1, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 64'd937, 32'hA5A5_5A5A);
        send_op(KIND_INSERT, 64'd1874, 32'h1234_5678);
        send_op(KIND_INSERT, 64'd0, 32'h1);
        send_op(KIND_FIND, 64'd0, 32'h0);
        send_op(KIND_FIND, '1, 32'h0);
        send_op(KIND_FIND, 64'd1874, 32'h0);
        send_op(KIND_FIND, 64'd2811, 32'h0);
        send_op(KIND_DELETE, 64'd937, 32'hFFFF_FFFF);
        send_op(KIND_FIND, 64'd1874, 32'h0);
        send_op(KIND_DELETE, 64'd0, 32'h0);
        send_op(KIND_DELETE, 64'd5, 32'h0);
        send_op(KIND_IGNORED, 64'h5555_AAAA_5555_AAAA, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 64'd937, 32'h5555_5555);
        send_op(KIND_DELETE, 64'd1874, 32'h0);
        send_op(KIND_FIND, 64'd937, 32'h0);
        send_op(KIND_DELETE, '1, 32'h0);
        run_random(250, 4000, 200);

        // two buckets; upper pwdata bits must be dropped
        drain();
        known_keys.delete();
        apb_write(ADDR_BUCKET_COUNT, 32'hFFFF_F802);
        run_random(150, 60, 40);
        // write to an unused register leaves the table alone
        drain();
        apb_write(ADDR_UNUSED, 32'h0000_0003);
        run_random(30, 60, 40);

        // zero acts as a single bucket
        drain();
        known_keys.delete();
        apb_write(ADDR_BUCKET_COUNT, 32'd0);
        run_random(80, 40, 30);

        // saturating bucket count, then a burst of inserts
        drain();
        known_keys.delete();
        apb_write(ADDR_BUCKET_COUNT, 32'h0000_07FF);
        for (int i = 0; i < 100; i++) begin
            logic [63:0] k;
            k = {$urandom, $urandom};
            if (i < 64) known_keys.push_back(k);
            send_op(KIND_INSERT, k, $urandom);
        end
        run_random(40, 0, 64);

        // largest bucket count, no idling on either side
        drain();
        known_keys.delete();
        idling_on = 1'b0;
        apb_write(ADDR_BUCKET_COUNT, 32'd1024);
        run_random(180, 0, 100);

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (table_sb.mismatches == 0 && table_sb.pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
